@@ rtl/sld_pkg.sv @@
`timescale 1ns / 1ps

package sld_pkg;

	// Number of sync bytes that open a frame.
	localparam int SYNC_BYTES = 4;
	localparam int MATCH_W = (SYNC_BYTES > 1) ? $clog2(SYNC_BYTES) : 1;

	localparam logic [31:0] SYNC_WORD_RESET = 32'h5359_4E43;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_FRAME_END = 1'b1
	} result_kind_t;

	typedef struct packed {
		result_kind_t result_kind;
		logic [7:0] payload_byte;
		logic [7:0] byte_position;
		logic [7:0] frame_length;
		logic checksum_match;
		logic frame_good;
	} sld_result_t;

	// Sync byte number idx, counted from the first byte sent. Bytes that
	// would lie above bit 31 of the register are zero.
	function automatic logic [7:0] sync_byte(logic [31:0] word, logic [MATCH_W-1:0] idx);
		int pos;
		pos = SYNC_BYTES - 1 - int'(idx);
		if (pos > 3) begin
			return 8'h00;
		end
		return 8'(word >> (8 * pos));
	endfunction

endpackage

@@ rtl/sld_in_reg.sv @@
`timescale 1ns / 1ps

module sld_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	import sld_pkg::*;

	// The register takes a new byte when empty or when its byte moves on.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

@@ rtl/sld_core.sv @@
`timescale 1ns / 1ps

module sld_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sync_word_we,
	input  logic [31:0]         sync_word,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	output logic                has_result,
	output sld_pkg::sld_result_t res
);
	import sld_pkg::*;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_LEN  = 2'd1,
		PH_DATA = 2'd2,
		PH_SUM  = 2'd3
	} phase_t;

	phase_t phase_q, phase_d;
	logic [MATCH_W-1:0] matched_q, matched_d;
	logic [7:0] length_q, length_d;
	logic [7:0] seen_q, seen_d;
	logic [7:0] xor_q, xor_d;
	logic [31:0] sync_word_q;
	logic [7:0] seen_inc;
	logic sum_ok;

	assign seen_inc = seen_q + 8'd1;
	assign sum_ok = (xor_q == rx_byte);
	assign has_result = (phase_q == PH_DATA) || (phase_q == PH_SUM);

	always_comb begin
		phase_d = phase_q;
		matched_d = matched_q;
		length_d = length_q;
		seen_d = seen_q;
		xor_d = xor_q;
		res = '0;
		case (phase_q)
			PH_HUNT: begin
				// A mismatching byte restarts the hunt and is not retried as a first byte.
				if (rx_byte == sync_byte(sync_word_q, matched_q)) begin
					if (matched_q == MATCH_W'(SYNC_BYTES - 1)) begin
						matched_d = '0;
						phase_d = PH_LEN;
					end else begin
						matched_d = matched_q + MATCH_W'(1);
					end
				end else begin
					matched_d = '0;
				end
			end
			PH_LEN: begin
				length_d = rx_byte;
				seen_d = 8'd0;
				xor_d = 8'd0;
				phase_d = (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
			end
			PH_DATA: begin
				res.result_kind = KIND_PAYLOAD;
				res.payload_byte = rx_byte;
				res.byte_position = seen_q;
				res.frame_length = length_q;
				xor_d = xor_q ^ rx_byte;
				seen_d = seen_inc;
				if (seen_inc == length_q) begin
					phase_d = PH_SUM;
				end
			end
			PH_SUM: begin
				res.result_kind = KIND_FRAME_END;
				res.frame_length = length_q;
				res.checksum_match = sum_ok;
				res.frame_good = sum_ok && (length_q != 8'd0);
				matched_d = '0;
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			matched_q <= '0;
			length_q <= 8'd0;
			seen_q <= 8'd0;
			xor_q <= 8'd0;
			sync_word_q <= SYNC_WORD_RESET;
		end else begin
			if (step) begin
				phase_q <= phase_d;
				matched_q <= matched_d;
				length_q <= length_d;
				seen_q <= seen_d;
				xor_q <= xor_d;
			end
			if (sync_word_we) begin
				sync_word_q <= sync_word;
			end
		end
	end

	a_data_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> (length_q != 8'd0) && (seen_q < length_q))
		else $error("payload count outside frame length");

	a_zero_len_to_sum: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_LEN && rx_byte == 8'd0 |=> phase_q == PH_SUM)
		else $error("zero length frame did not go to checksum");

	a_sum_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_SUM |=> phase_q == PH_HUNT && matched_q == '0)
		else $error("frame end did not restart the sync hunt");

endmodule

@@ rtl/sld_out_reg.sv @@
`timescale 1ns / 1ps

module sld_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  sld_pkg::sld_result_t res,
	output logic                can_load,
	output logic                out_valid,
	input  logic                out_ready,
	output sld_pkg::sld_result_t res_q
);
	import sld_pkg::*;

	// A new result may enter while the held one is being transferred.
	assign can_load = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

@@ rtl/sync_length_xor_deframer.sv @@
`timescale 1ns / 1ps

// Deframer for a byte stream: sync word, length byte, payload, XOR checksum.
// Input channel: rx_byte with in_valid / in_ready, one byte per transfer.
// Output channel: out_valid / out_ready with one result per transfer:
// a payload byte with its position, or a frame end with length and verdict.
// Sync bytes and the length byte produce no result.
// The sync word is written through sync_word_we / sync_word; the user
// must do so only while idle, which the block does not enforce.
// A byte taken goes into the input register and its result then into
// the result register, which drives the output.
// Throughput: one byte per cycle while the receiver keeps out_ready high.
// When the receiver stalls, the result register holds its result and one
// more byte waits in the input register; bytes that produce no result still
// pass through. Then in_ready drops until the held result is transferred.
// Reset empties both registers, restarts the sync hunt and loads the sync
// word with ASCII "SYNC".
module sync_length_xor_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sync_word_we,
	input  logic [31:0] sync_word,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [7:0]  payload_byte,
	output logic [7:0]  byte_position,
	output logic [7:0]  frame_length,
	output logic        checksum_match,
	output logic        frame_good
);
	import sld_pkg::*;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic advance;
	logic has_result;
	logic can_load;
	sld_result_t res;
	sld_result_t res_q;

	assign advance = valid_s1 && (!has_result || can_load);

	sld_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	sld_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.sync_word_we (sync_word_we),
		.sync_word    (sync_word),
		.step         (advance),
		.rx_byte      (byte_s1),
		.has_result   (has_result),
		.res          (res)
	);

	sld_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && has_result),
		.res       (res),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign result_kind = res_q.result_kind;
	assign payload_byte = res_q.payload_byte;
	assign byte_position = res_q.byte_position;
	assign frame_length = res_q.frame_length;
	assign checksum_match = res_q.checksum_match;
	assign frame_good = res_q.frame_good;

endmodule
